>>> design/assert_macros.svh
// Assertion macros used by the codec top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside reset.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/hsc_pkg.sv
// Types, constants and code-layout functions for the Hamming SEC codec.
package hsc_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int DATA_W        = 57;
  localparam int CODE_W        = 63;
  localparam int LEN_W         = 6;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic REG_DATA_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_PARITY    = 2'd1,
    ERR_CORRECTED = 2'd2,
    ERR_RANGE     = 2'd3
  } err_kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  syndrome;
    logic [DATA_W-1:0] decoded_data;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] encoded_word;
    err_kind_t         error_kind;
  } result_t;

  // Code position p (1-based) holds a parity bit when p is a power of two.
  function automatic logic is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Data bit index stored at word bit k (only meaningful for data positions).
  function automatic int data_index(input int k);
    int cnt;
    cnt = 0;
    for (int p = 1; p <= k; p++) begin
      if (!is_pow2(p)) cnt++;
    end
    return cnt;
  endfunction

  // Word bit that carries data bit j.
  function automatic int data_pos(input int j);
    int cnt;
    int res;
    cnt = 0;
    res = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (!is_pow2(p)) begin
        if (cnt == j) res = p - 1;
        cnt++;
      end
    end
    return res;
  endfunction

  // Word bits whose position has bit b set.
  function automatic logic [CODE_W-1:0] syn_mask(input int b);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int k = 0; k < CODE_W; k++) begin
      m[k] = (((k + 1) >> b) & 1) != 0;
    end
    return m;
  endfunction

  // Parity bit count for n data bits (n already clamped to 1..57).
  function automatic logic [2:0] parity_count(input logic [LEN_W-1:0] n);
    logic [2:0] r;
    if (n <= 6'd1) r = 3'd2;
    else if (n <= 6'd4) r = 3'd3;
    else if (n <= 6'd11) r = 3'd4;
    else if (n <= 6'd26) r = 3'd5;
    else r = 3'd6;
    return r;
  endfunction

endpackage

>>> design/hsc_cfg.sv
// APB-style register file holding the block length.
module hsc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hsc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hsc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [hsc_pkg::LEN_W-1:0]        data_length
);

  logic [hsc_pkg::LEN_W-1:0] data_length_r;
  logic [hsc_pkg::LEN_W-1:0] data_length_nxt;
  logic                      sel_len;

  assign pready  = 1'b1;
  assign sel_len = (paddr[2] == hsc_pkg::REG_DATA_LENGTH);

  always_comb begin
    data_length_nxt = data_length_r;
    if (psel && penable && pwrite && pready && sel_len) begin
      data_length_nxt = pwdata[hsc_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= 6'(hsc_pkg::MAX_DATA_BITS);
    end else begin
      data_length_r <= data_length_nxt;
    end
  end

  assign prdata = sel_len ? {(hsc_pkg::CFG_DATA_W - hsc_pkg::LEN_W)'(0), data_length_r}
                          : '0;
  assign data_length = data_length_r;

endmodule

>>> design/hsc_core.sv
// Combinational encode / syndrome / correct / strip logic for one block.
module hsc_core (
  input  logic                          mode,
  input  logic [hsc_pkg::DATA_W-1:0]    data_word,
  input  logic [hsc_pkg::CODE_W-1:0]    code_word,
  input  logic [hsc_pkg::LEN_W-1:0]     data_length,
  output hsc_pkg::result_t              res
);

  logic [hsc_pkg::LEN_W-1:0]  n_eff;
  logic [hsc_pkg::LEN_W-1:0]  len;
  logic [hsc_pkg::CODE_W-1:0] lmask;
  logic [hsc_pkg::DATA_W-1:0] dmask;
  logic [hsc_pkg::CODE_W-1:0] placed;
  logic [hsc_pkg::CODE_W-1:0] rx;
  logic [hsc_pkg::CODE_W-1:0] word_in;
  logic [hsc_pkg::CODE_W-1:0] enc;
  logic [hsc_pkg::CODE_W-1:0] flip;
  logic [hsc_pkg::CODE_W-1:0] corrected;
  logic [hsc_pkg::DATA_W-1:0] dec;
  logic [hsc_pkg::LEN_W-1:0]  syn;
  logic                       fix_ok;
  hsc_pkg::err_kind_t         kind;

  // Clamp the length register into 1..MAX_DATA_BITS.
  always_comb begin
    if (data_length == '0) n_eff = 6'd1;
    else if (data_length > 6'(hsc_pkg::MAX_DATA_BITS)) n_eff = 6'(hsc_pkg::MAX_DATA_BITS);
    else n_eff = data_length;
  end

  assign len = n_eff + {3'b000, hsc_pkg::parity_count(n_eff)};

  for (genvar k = 0; k < hsc_pkg::CODE_W; k++) begin : g_pos
    localparam int DI = hsc_pkg::data_index(k);
    assign lmask[k] = (6'(k) < len);
    if (hsc_pkg::is_pow2(k + 1)) begin : g_par
      localparam int B = $clog2(k + 1);
      assign placed[k] = 1'b0;
      assign enc[k]    = syn[B];
    end else begin : g_dat
      assign placed[k] = data_word[DI] & dmask[DI];
      assign enc[k]    = placed[k];
    end
    assign flip[k] = mode && fix_ok && (syn == 6'(k + 1));
  end

  for (genvar j = 0; j < hsc_pkg::DATA_W; j++) begin : g_dat_out
    localparam int P = hsc_pkg::data_pos(j);
    assign dmask[j] = (6'(j) < n_eff);
    assign dec[j]   = corrected[P] & dmask[j];
  end

  assign rx      = code_word & lmask;
  assign word_in = mode ? rx : placed;

  // Syndrome bit b: parity over the positions whose index has bit b set.
  for (genvar b = 0; b < hsc_pkg::LEN_W; b++) begin : g_syn
    localparam logic [hsc_pkg::CODE_W-1:0] M = hsc_pkg::syn_mask(b);
    assign syn[b] = ^(word_in & M);
  end

  assign fix_ok    = (syn != '0) && (syn <= len);
  assign corrected = rx ^ flip;

  always_comb begin
    priority if (syn == '0) kind = hsc_pkg::ERR_NONE;
    else if (syn > len)     kind = hsc_pkg::ERR_RANGE;
    else if ($onehot(syn))  kind = hsc_pkg::ERR_PARITY;
    else                    kind = hsc_pkg::ERR_CORRECTED;
  end

  always_comb begin
    res.code_length = len;
    if (mode) begin
      res.encoded_word = corrected;
      res.decoded_data = dec;
      res.syndrome     = syn;
      res.error_kind   = kind;
    end else begin
      res.encoded_word = enc;
      res.decoded_data = '0;
      res.syndrome     = '0;
      res.error_kind   = hsc_pkg::ERR_NONE;
    end
  end

endmodule

>>> design/hamming_sec_codec.sv
// Top level of the Hamming SEC codec: input stage, codec logic, result stage.
//
//   channel  | direction | handshake          | payload
//   in_      | slave     | tvalid/tready      | tdata: data_word, code_word; tuser: mode
//   out_     | master    | tvalid/tready      | tdata: word, length, data, syndrome; tuser: kind
//   cfg_     | slave     | APB psel/penable   | data_length at byte address 0
//
// One request per cycle sustained while out_tready stays high; an accepted request
// is registered in the input register, then passes through the codec logic into
// the result register. Reset clears both stage valids and sets data_length to 57.
// A stalled result holds in the result register while one more request waits in
// the input register; in_tready drops only when both stages are full.
`include "assert_macros.svh"

module hamming_sec_codec (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [119:0]                    in_tdata,  // data_word[56:0], code_word[119:57]
  input  logic [0:0]                      in_tuser,  // mode[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // encoded_word[62:0], code_length[68:63], decoded_data[125:69], syndrome[131:126], zero pad
  output logic [135:0]                    out_tdata,
  output logic [1:0]                      out_tuser, // error_kind[1:0]
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hsc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [hsc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [hsc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  logic [hsc_pkg::LEN_W-1:0]  data_length;
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_mode_r;
  logic [hsc_pkg::DATA_W-1:0] s1_data_r;
  logic [hsc_pkg::CODE_W-1:0] s1_code_r;
  logic                       out_valid_r, out_valid_nxt;
  hsc_pkg::result_t           out_res_r;
  hsc_pkg::result_t           core_res;
  logic                       out_free;
  logic                       in_fire;

  hsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .data_length (data_length)
  );

  hsc_core u_core (
    .mode        (s1_mode_r),
    .data_word   (s1_data_r),
    .code_word   (s1_code_r),
    .data_length (data_length),
    .res         (core_res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !out_free);
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload stages carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser[0];
      s1_data_r <= in_tdata[56:0];
      s1_code_r <= in_tdata[119:57];
    end
    if (out_free) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.syndrome, out_res_r.decoded_data,
                       out_res_r.code_length, out_res_r.encoded_word};
  assign out_tuser  = out_res_r.error_kind;

  `ASSERT_ON(a_s1_loads, in_fire |=> s1_valid_r, "accepted request did not reach input stage")
  `ASSERT_ON(a_s1_moves, (s1_valid_r && out_free) |=> out_valid_r,
             "input stage advanced without a result")
  `ASSERT_ON(a_clean_syn, (out_valid_r && out_res_r.error_kind == hsc_pkg::ERR_NONE)
             |-> (out_res_r.syndrome == '0), "clean result with nonzero syndrome")
  `ASSERT_ON(a_par_syn, (out_valid_r && out_res_r.error_kind == hsc_pkg::ERR_PARITY)
             |-> $onehot(out_res_r.syndrome), "parity-only error with multi-bit syndrome")
  `ASSERT_NEVER(a_len_mask, out_valid_r &&
                ((out_res_r.encoded_word >> out_res_r.code_length) != '0),
                "code word has bits beyond code length")

endmodule

>>> sim/hamming_sec_codec_tb.sv
// Self-checking testbench for hamming_sec_codec: directed table, random traffic, APB setup.
`timescale 1ns / 1ps

module hamming_sec_codec_tb;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam logic [hsc_pkg::CFG_ADDR_W-1:0] ADDR_DATA_LENGTH = 3'd0;
  localparam logic [hsc_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 150;
  localparam logic [56:0] ONES57 = 57'h1FF_FFFF_FFFF_FFFF;
  localparam logic [62:0] ONES63 = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [5:0]         len_set;
    logic               mode;
    logic [56:0]        dw;
    logic [62:0]        cw;
    logic               typed;
    logic [62:0]        w_word;
    logic [5:0]         w_len;
    logic [56:0]        w_data;
    logic [5:0]         w_syn;
    hsc_pkg::err_kind_t w_kind;
  } vec_t;

  localparam int N_DIR = 23;
  // Rows with typed = 0 are checked against the predictor.
  localparam vec_t DIR_TAB [N_DIR] = '{
    '{6'd57, MODE_ENCODE, 57'd0, 63'd0, 1'b1, 63'd0, 6'd63, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd57, MODE_DECODE, 57'd0, 63'd0, 1'b1, 63'd0, 6'd63, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd57, MODE_ENCODE, ONES57, 63'd0, 1'b1, ONES63, 6'd63, 57'd0, 6'd0,
      hsc_pkg::ERR_NONE},
    '{6'd57, MODE_DECODE, 57'd0, ONES63, 1'b1, ONES63, 6'd63, ONES57, 6'd0,
      hsc_pkg::ERR_NONE},
    '{6'd57, MODE_DECODE, 57'd0, 63'h1, 1'b1, 63'd0, 6'd63, 57'd0, 6'd1,
      hsc_pkg::ERR_PARITY},
    '{6'd57, MODE_DECODE, 57'd0, 63'h4, 1'b1, 63'd0, 6'd63, 57'd0, 6'd3,
      hsc_pkg::ERR_CORRECTED},
    '{6'd57, MODE_DECODE, 57'd0, 63'h8000_0000, 1'b1, 63'd0, 6'd63, 57'd0, 6'd32,
      hsc_pkg::ERR_PARITY},
    '{6'd57, MODE_DECODE, 57'd0, 63'h4000_0000_0000_0000, 1'b1, 63'd0, 6'd63, 57'd0, 6'd63,
      hsc_pkg::ERR_CORRECTED},
    '{6'd57, MODE_ENCODE, 57'h0A5_A5A5_A5A5_A5A5, 63'd0, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0,
      hsc_pkg::ERR_NONE},
    '{6'd57, MODE_DECODE, 57'd0, 63'h6, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd63, MODE_ENCODE, 57'h155_5555_5555_5555, 63'd0, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0,
      hsc_pkg::ERR_NONE},
    // positions 6 and 9 give syndrome 15, past the 9-bit code
    '{6'd5, MODE_DECODE, 57'd0, 63'h120, 1'b1, 63'h120, 6'd9, 57'h14, 6'd15,
      hsc_pkg::ERR_RANGE},
    '{6'd5, MODE_ENCODE, ONES57, 63'd0, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd5, MODE_DECODE, 57'd0, ONES63, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd1, MODE_ENCODE, 57'd1, 63'd0, 1'b1, 63'h7, 6'd3, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd1, MODE_ENCODE, ONES57, 63'd0, 1'b1, 63'h7, 6'd3, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd1, MODE_DECODE, 57'd0, ONES63, 1'b1, 63'h7, 6'd3, 57'd1, 6'd0, hsc_pkg::ERR_NONE},
    // zero length behaves as one data bit
    '{6'd0, MODE_DECODE, 57'd0, 63'h2, 1'b1, 63'd0, 6'd3, 57'd0, 6'd2, hsc_pkg::ERR_PARITY},
    '{6'd4, MODE_ENCODE, 57'hF, 63'd0, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0, hsc_pkg::ERR_NONE},
    '{6'd26, MODE_DECODE, 57'd0, 63'h2BAD_C0DE_1234_5678, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0,
      hsc_pkg::ERR_NONE},
    '{6'd27, MODE_ENCODE, 57'h0FE_DCBA_9876_5432, 63'd0, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0,
      hsc_pkg::ERR_NONE},
    '{6'd11, MODE_DECODE, 57'd0, 63'h7654_3210_FEDC_BA98, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0,
      hsc_pkg::ERR_NONE},
    '{6'd2, MODE_ENCODE, 57'h3, 63'd0, 1'b0, 63'd0, 6'd0, 57'd0, 6'd0, hsc_pkg::ERR_NONE}
  };

  localparam logic [5:0] PHASE_LEN [10] = '{6'd57, 6'd1, 6'd63, 6'd0, 6'd5, 6'd26, 6'd27,
                                             6'd2, 6'd4, 6'd11};

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [119:0]                   in_tdata;   // data_word[56:0], code_word[119:57]
  logic [0:0]                     in_tuser;   // mode[0]
  logic                           out_tvalid;
  logic                           out_tready;
  // encoded_word[62:0], code_length[68:63], decoded_data[125:69], syndrome[131:126]
  logic [135:0]                   out_tdata;
  logic [1:0]                     out_tuser;  // error_kind[1:0]
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [hsc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [hsc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [hsc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  hsc_pkg::result_t pending_results[$];
  logic [5:0]       len_reg_copy;
  bit               steady;
  bit               squeeze_req;
  int               fail_count;
  int               n_encode;
  int               n_decode;
  int               n_len_writes;
  int               kinds_seen[4];

  hamming_sec_codec u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Encode or check one block at the given length setting.
  function automatic hsc_pkg::result_t hamming_predict(input logic mode,
                                                       input logic [56:0] dw,
                                                       input logic [62:0] cw,
                                                       input logic [5:0] len);
    hsc_pkg::result_t res;
    logic [63:0]      w;
    logic [56:0]      d;
    int               n;
    int               r;
    int               cl;
    int               s;
    int               j;
    n = (len == 6'd0) ? 1 : ((int'(len) > hsc_pkg::MAX_DATA_BITS) ? hsc_pkg::MAX_DATA_BITS
                                                                  : int'(len));
    r = 0;
    while (n + r + 1 > (1 << r)) r++;
    cl = n + r;
    w = '0;
    d = '0;
    j = 0;
    if (mode == MODE_ENCODE) begin
      for (int p = 1; p <= cl; p++) begin
        if ((p & (p - 1)) != 0) begin
          w[p-1] = dw[j];
          j++;
        end
      end
    end else begin
      w = {1'b0, cw} & ((64'd1 << cl) - 64'd1);
    end
    s = 0;
    for (int p = 1; p <= cl; p++) begin
      if (w[p-1]) s ^= p;
    end
    res = '0;
    res.code_length = 6'(cl);
    if (mode == MODE_ENCODE) begin
      for (int b = 0; b < 6; b++) begin
        if (((s >> b) & 1) != 0) w[(1 << b) - 1] = 1'b1;
      end
    end else begin
      res.syndrome = 6'(s);
      if (s == 0) begin
        res.error_kind = hsc_pkg::ERR_NONE;
      end else if (s > cl) begin
        res.error_kind = hsc_pkg::ERR_RANGE;
      end else begin
        res.error_kind = ((s & (s - 1)) == 0) ? hsc_pkg::ERR_PARITY : hsc_pkg::ERR_CORRECTED;
        w[s-1] = ~w[s-1];
      end
      j = 0;
      for (int p = 1; p <= cl; p++) begin
        if ((p & (p - 1)) != 0) begin
          d[j] = w[p-1];
          j++;
        end
      end
      res.decoded_data = d;
    end
    res.encoded_word = w[62:0];
    return res;
  endfunction

  task automatic send_request(input logic mode, input logic [56:0] dw, input logic [62:0] cw,
                              input hsc_pkg::result_t want);
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {cw, dw};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), want);
    if (mode == MODE_ENCODE) n_encode++;
    else n_decode++;
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [hsc_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [hsc_pkg::CFG_DATA_W-1:0] wdata,
                          output logic [hsc_pkg::CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_length_reg();
    logic [hsc_pkg::CFG_DATA_W-1:0] rd;
    apb_xfer(1'b0, ADDR_DATA_LENGTH, '0, rd);
    if (rd !== {26'd0, len_reg_copy}) begin
      $display("%0t: data_length readback mismatch: expected %0d, actual %0h",
               $time, len_reg_copy, rd);
      fail_count++;
    end
  endtask

  task automatic set_length(input logic [5:0] v);
    logic [hsc_pkg::CFG_DATA_W-1:0] rd;
    logic [31:0]                    junk;
    junk = $urandom;
    drain();
    // upper write bits carry noise; only the low six are kept
    apb_xfer(1'b1, ADDR_DATA_LENGTH, {junk[31:6], v}, rd);
    len_reg_copy = v;
    n_len_writes++;
    check_length_reg();
  endtask

  // Consume results and compare them against the oldest expectation.
  initial begin : result_sink
    hsc_pkg::result_t got;
    hsc_pkg::result_t want;
    int               hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.encoded_word = out_tdata[62:0];
        got.code_length  = out_tdata[68:63];
        got.decoded_data = out_tdata[125:69];
        got.syndrome     = out_tdata[131:126];
        got.error_kind   = hsc_pkg::err_kind_t'(out_tuser);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: word %h len %0d data %h syn %0d kind %0d",
                   $time, got.encoded_word, got.code_length, got.decoded_data,
                   got.syndrome, got.error_kind);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch", $time);
            $display("  expected: word %h len %0d data %h syn %0d kind %0d",
                     want.encoded_word, want.code_length, want.decoded_data,
                     want.syndrome, want.error_kind);
            $display("  actual:   word %h len %0d data %h syn %0d kind %0d",
                     got.encoded_word, got.code_length, got.decoded_data,
                     got.syndrome, got.error_kind);
            fail_count++;
          end else begin
            kinds_seen[got.error_kind]++;
          end
        end
      end
      if (squeeze_req) begin
        hold_left   = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      out_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 19);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run stopped after %0d cycles with %0d results pending",
             $time, cycles, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    vec_t                           row;
    hsc_pkg::result_t               want;
    hsc_pkg::result_t               clean;
    logic                           mode;
    logic [63:0]                    r64;
    logic [62:0]                    cw;
    logic [62:0]                    lmask;
    logic [hsc_pkg::CFG_DATA_W-1:0] rd;
    logic [5:0]                     plen;
    int                             nerr;
    steady       = 1'b0;
    squeeze_req  = 1'b0;
    fail_count   = 0;
    n_encode     = 0;
    n_decode     = 0;
    n_len_writes = 0;
    len_reg_copy = 6'd57;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    check_length_reg();
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TAB[i];
      if (row.len_set != len_reg_copy) set_length(row.len_set);
      if (row.typed) begin
        want.encoded_word = row.w_word;
        want.code_length  = row.w_len;
        want.decoded_data = row.w_data;
        want.syndrome     = row.w_syn;
        want.error_kind   = row.w_kind;
      end else begin
        want = hamming_predict(row.mode, row.dw, row.cw, len_reg_copy);
      end
      send_request(row.mode, row.dw, row.cw, want);
    end

    // a write to an unmapped address must leave data_length alone
    drain();
    r64 = {$urandom, $urandom};
    apb_xfer(1'b1, ADDR_UNMAPPED, r64[31:0], rd);
    check_length_reg();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      plen = (ph < 10) ? PHASE_LEN[ph] : 6'($urandom_range(63));
      if (plen != len_reg_copy) set_length(plen);
      steady = (ph == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 4 && k == 30) squeeze_req = 1'b1;
        if (ph == 6 && k == 30) drain();
        mode = 1'($urandom_range(1));
        r64  = {$urandom, $urandom};
        cw   = 63'({$urandom, $urandom});
        if (mode == MODE_DECODE && $urandom_range(99) >= 15) begin
          // valid codeword with zero, one or two flipped bits, with or without noise above the code
          clean = hamming_predict(MODE_ENCODE, r64[56:0], '0, len_reg_copy);
          lmask = 63'((64'd1 << clean.code_length) - 64'd1);
          nerr  = ($urandom_range(99) < 30) ? 0 : (($urandom_range(99) < 70) ? 1 : 2);
          if ($urandom_range(1)) cw = clean.encoded_word | (cw & ~lmask);
          else cw = clean.encoded_word;
          repeat (nerr) begin
            cw[$urandom_range(int'(clean.code_length) - 1)] ^= 1'b1;
          end
        end
        want = hamming_predict(mode, r64[56:0], cw, len_reg_copy);
        send_request(mode, r64[56:0], cw, want);
      end
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests (%0d encode, %0d decode) across %0d length writes.",
             n_encode + n_decode, n_encode, n_decode, n_len_writes);
    $display("Checks by outcome: clean %0d, parity-only %0d, corrected %0d, out of range %0d.",
             kinds_seen[hsc_pkg::ERR_NONE], kinds_seen[hsc_pkg::ERR_PARITY],
             kinds_seen[hsc_pkg::ERR_CORRECTED], kinds_seen[hsc_pkg::ERR_RANGE]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/hsc_pkg.sv
design/hsc_cfg.sv
design/hsc_core.sv
design/hamming_sec_codec.sv
sim/hamming_sec_codec_tb.sv
